@@ rtl/crtm_pkg.sv @@
// ----------------------------------------------------------------------------
// crtm_pkg
// Shared types, constants and sequence-generator functions for the CCSDS
// three-mode randomizer.
// ----------------------------------------------------------------------------
package crtm_pkg;

    localparam int ValueWidth  = 16;
    localparam int FormatWidth = 2;
    localparam int SeqWidth    = 8;

    // item format codes
    localparam logic [FormatWidth-1:0] FMT_HARD = 2'd0;
    localparam logic [FormatWidth-1:0] FMT_BYTE = 2'd1;
    localparam logic [FormatWidth-1:0] FMT_SOFT = 2'd2;
    localparam logic [FormatWidth-1:0] FMT_NONE = 2'd3;

    localparam logic [FormatWidth-1:0] FMT_RESET  = FMT_BYTE;
    localparam logic [SeqWidth-1:0]    SEQ_SEED   = 8'hFF;
    localparam logic [ValueWidth-1:0]  SAMPLE_MAX = 16'h7FFF;
    localparam logic [ValueWidth-1:0]  SAMPLE_MIN = 16'h8000;

    typedef logic [FormatWidth-1:0] format_t;
    typedef logic [SeqWidth-1:0]    seq_t;
    typedef logic [ValueWidth-1:0]  value_t;

    typedef struct packed {
        logic   valid;
        value_t data;
    } result_t;

    // One step of h(x) = x^8 + x^7 + x^5 + x^3 + 1, output bit in bit 7.
    function automatic seq_t lfsr_step(input seq_t s);
        logic fb;
        fb = s[7] ^ s[4] ^ s[2] ^ s[0];
        return {s[SeqWidth-2:0], fb};
    endfunction

    // Eight steps; the state before the advance is the byte being used.
    function automatic seq_t lfsr_adv8(input seq_t s);
        seq_t t;
        t = s;
        for (int i = 0; i < SeqWidth; i++)
        begin
            t = lfsr_step(t);
        end
        return t;
    endfunction

endpackage

@@ rtl/crtm_core.sv @@
// ----------------------------------------------------------------------------
// crtm_core
// Combinational randomizer datapath: applies the sequence to one request
// in the selected format and computes the next generator state.
// ----------------------------------------------------------------------------
module crtm_core
(
    input  crtm_pkg::format_t item_format,
    input  crtm_pkg::value_t  value,
    input  logic              frame_start,
    input  crtm_pkg::seq_t    lfsr_cur,
    output crtm_pkg::result_t result,
    output crtm_pkg::seq_t    lfsr_next
);
    import crtm_pkg::*;

    seq_t   seq;
    value_t neg;

    // frame start restarts the sequence before this request is used
    assign seq = frame_start ? SEQ_SEED : lfsr_cur;
    assign neg = (value == SAMPLE_MIN) ? SAMPLE_MAX : (~value + value_t'(1));

    always_comb
    begin
        result.valid = 1'b1;
        result.data  = '0;
        lfsr_next    = seq;
        case (item_format)
            FMT_HARD:
            begin
                result.data = {{(ValueWidth-1){1'b0}}, (|value) ^ seq[SeqWidth-1]};
                lfsr_next   = lfsr_step(seq);
            end
            FMT_BYTE:
            begin
                result.data = {{(ValueWidth-SeqWidth){1'b0}}, value[SeqWidth-1:0] ^ seq};
                lfsr_next   = lfsr_adv8(seq);
            end
            FMT_SOFT:
            begin
                result.data = seq[SeqWidth-1] ? neg : value;
                lfsr_next   = lfsr_step(seq);
            end
            default:
            begin
                // unknown format: no result, sequence holds (restart still applies)
                result.valid = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/ccsds_randomizer_three_mode.sv @@
// ----------------------------------------------------------------------------
// ccsds_randomizer_three_mode
// CCSDS pseudo-randomizer (x^8+x^7+x^5+x^3+1, all-ones seed, MSB first)
// for hard-bit, byte and soft-sample streams.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                 | tuser        | notes
//  ---------+-----+-----------------------+--------------+---------------------
//  s_axis   | in  | [15:0] value          | [0] frame_start | input requests
//  m_axis   | out | [15:0] scrambled      | -            | one per request
//  cfg      | in  | [1:0] item_format     | -            | write on cfg_we
//
//  One request per clock; result on m_axis the cycle after acceptance.
//  The 8-bit generator advances up to eight steps combinationally per request.
//  s_axis_tready is low only while a result waits and m_axis_tready is low.
//  Format 3 consumes the request without a result.
//  Reset: item format = byte, generator = all ones, output register empty.
//
module ccsds_randomizer_three_mode
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_we,
    input  crtm_pkg::format_t      cfg_wdata,       // [1:0] item_format
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  crtm_pkg::value_t       s_axis_tdata,    // [15:0] value
    input  logic                   s_axis_tuser,    // [0] frame_start
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output crtm_pkg::value_t       m_axis_tdata     // [15:0] scrambled
);
    import crtm_pkg::*;

    format_t format_reg;
    seq_t    lfsr_reg;
    seq_t    lfsr_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    value_t  out_data_reg;
    result_t res;
    logic    s_acc;

    // output register frees up when empty or being drained this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    crtm_core u_core
    (
        .item_format (format_reg),
        .value       (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .lfsr_cur    (lfsr_reg),
        .result      (res),
        .lfsr_next   (lfsr_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s_acc)
        begin
            out_valid_next = res.valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg    <= FMT_RESET;
            lfsr_reg      <= SEQ_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                format_reg <= cfg_wdata;
            end
            if (s_acc)
            begin
                lfsr_reg <= lfsr_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (s_acc && res.valid)
        begin
            out_data_reg <= res.data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // generator never falls into the all-zero lockup state
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("sequence generator reached all-zero state");

    // unknown format consumes the request and leaves no result
    a_none_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && format_reg == FMT_NONE |=> !m_axis_tvalid)
        else $error("result produced for unknown format");

    // byte at frame start is scrambled with the seed byte
    a_byte_seed: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_axis_tuser && format_reg == FMT_BYTE |=>
            m_axis_tvalid && m_axis_tdata == {8'h00, $past(s_axis_tdata[7:0]) ^ SEQ_SEED})
        else $error("frame start did not restart the sequence");

    // hard-bit results are a single bit
    a_hard_one_bit: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && format_reg == FMT_HARD |=> m_axis_tdata[15:1] == '0)
        else $error("hard-bit result wider than one bit");

endmodule
